>>> rtl/core/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit: assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RAU_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rstn, prop, msg)
`define RAU_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation, relation and status codes, micro-op encoding and the microprogram.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned PC_W    = 5;

  typedef enum logic [2:0] {
    KIND_MAKE = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_CMP  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } relation_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_GINIT = 4'd0,
    OP_GSTEP = 4'd1,
    OP_GFIN  = 4'd2,
    OP_DSTEP = 4'd3,
    OP_DNEXT = 4'd4,
    OP_MLOAD = 4'd5,
    OP_MSTEP = 4'd6,
    OP_MSAVE = 4'd7,
    OP_SUM   = 4'd8,
    OP_FIN   = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT = 2'd0,
    C_LOOP = 2'd1,
    C_GCD  = 2'd2,
    C_END  = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    SEL_P = 2'd0,
    SEL_Q = 2'd1,
    SEL_D = 2'd2
  } sel_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    sel_e            sel;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] UPC_GINIT   = 5'd0;
  localparam logic [PC_W-1:0] UPC_GSTEP   = 5'd1;
  localparam logic [PC_W-1:0] UPC_GFIN    = 5'd2;
  localparam logic [PC_W-1:0] UPC_DIV_N   = 5'd3;
  localparam logic [PC_W-1:0] UPC_DNEXT   = 5'd4;
  localparam logic [PC_W-1:0] UPC_DIV_D   = 5'd5;
  localparam logic [PC_W-1:0] UPC_FIN_M   = 5'd6;
  localparam logic [PC_W-1:0] UPC_MLOAD_P = 5'd7;
  localparam logic [PC_W-1:0] UPC_MSTEP_P = 5'd8;
  localparam logic [PC_W-1:0] UPC_MSAVE_P = 5'd9;
  localparam logic [PC_W-1:0] UPC_MLOAD_Q = 5'd10;
  localparam logic [PC_W-1:0] UPC_MSTEP_Q = 5'd11;
  localparam logic [PC_W-1:0] UPC_MSAVE_Q = 5'd12;
  localparam logic [PC_W-1:0] UPC_MLOAD_D = 5'd13;
  localparam logic [PC_W-1:0] UPC_MSTEP_D = 5'd14;
  localparam logic [PC_W-1:0] UPC_MSAVE_D = 5'd15;
  localparam logic [PC_W-1:0] UPC_SUM     = 5'd16;
  localparam logic [PC_W-1:0] UPC_FIN_A   = 5'd17;

  function automatic ucode_t uword(op_e op, cond_e cond, sel_e sel,
                                   logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.sel    = sel;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      UPC_GINIT:   w = uword(OP_GINIT, C_NEXT, SEL_P, UPC_GINIT);
      UPC_GSTEP:   w = uword(OP_GSTEP, C_GCD,  SEL_P, UPC_GSTEP);
      UPC_GFIN:    w = uword(OP_GFIN,  C_NEXT, SEL_P, UPC_GFIN);
      UPC_DIV_N:   w = uword(OP_DSTEP, C_LOOP, SEL_P, UPC_DIV_N);
      UPC_DNEXT:   w = uword(OP_DNEXT, C_NEXT, SEL_P, UPC_DNEXT);
      UPC_DIV_D:   w = uword(OP_DSTEP, C_LOOP, SEL_P, UPC_DIV_D);
      UPC_FIN_M:   w = uword(OP_FIN,   C_END,  SEL_P, UPC_FIN_M);
      UPC_MLOAD_P: w = uword(OP_MLOAD, C_NEXT, SEL_P, UPC_MLOAD_P);
      UPC_MSTEP_P: w = uword(OP_MSTEP, C_LOOP, SEL_P, UPC_MSTEP_P);
      UPC_MSAVE_P: w = uword(OP_MSAVE, C_NEXT, SEL_P, UPC_MSAVE_P);
      UPC_MLOAD_Q: w = uword(OP_MLOAD, C_NEXT, SEL_Q, UPC_MLOAD_Q);
      UPC_MSTEP_Q: w = uword(OP_MSTEP, C_LOOP, SEL_Q, UPC_MSTEP_Q);
      UPC_MSAVE_Q: w = uword(OP_MSAVE, C_NEXT, SEL_Q, UPC_MSAVE_Q);
      UPC_MLOAD_D: w = uword(OP_MLOAD, C_NEXT, SEL_D, UPC_MLOAD_D);
      UPC_MSTEP_D: w = uword(OP_MSTEP, C_LOOP, SEL_D, UPC_MSTEP_D);
      UPC_MSAVE_D: w = uword(OP_MSAVE, C_NEXT, SEL_D, UPC_MSAVE_D);
      UPC_SUM:     w = uword(OP_SUM,   C_NEXT, SEL_P, UPC_SUM);
      default:     w = uword(OP_FIN,   C_END,  SEL_P, UPC_FIN_A);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Microcoded fraction reduce, add, sub, mul, div and compare on one datapath.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Fields
// command   in         start, busy         kind_i, a_num_i, a_den_i, b_num_i, b_den_i
// result    out        done_o (strobe)     res_num_o, res_den_o, relation_o, status_o
//
// A word is taken when start is high and busy is low; busy stays high until the
// result strobe. Reduce (make) runs binary GCD steps until an operand is zero, then
// two restoring divisions one bit a cycle. Add, sub, mul, div and compare rest on
// three shift-add products formed one bit a cycle; unused kinds go straight to the
// result strobe. Reset clears the sequencer; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        done_o,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic [1:0]  relation_o,
  output logic [1:0]  status_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned PW = 2 * WORD_WIDTH - 1;
  localparam int unsigned SW = 2 * WORD_WIDTH + 1;
  localparam int unsigned CW = $clog2(WORD_WIDTH);
  localparam int unsigned FW = rau_pkg::FIELD_W;
  localparam int unsigned PCW = rau_pkg::PC_W;

  logic [W-1:0] an_w, ad_w, bn_w, bd_w;

  if (W <= FW) begin : g_in_narrow
    assign an_w = a_num_i[W-1:0];
    assign ad_w = a_den_i[W-1:0];
    assign bn_w = b_num_i[W-1:0];
    assign bd_w = b_den_i[W-1:0];
  end else begin : g_in_wide
    assign an_w = {{(W-FW){a_num_i[FW-1]}}, a_num_i};
    assign ad_w = {{(W-FW){a_den_i[FW-1]}}, a_den_i};
    assign bn_w = {{(W-FW){b_num_i[FW-1]}}, b_num_i};
    assign bd_w = {{(W-FW){b_den_i[FW-1]}}, b_den_i};
  end

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [PCW-1:0]    pc_q, pc_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [2:0]        kind_q, kind_d;
  logic [W-1:0]      an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0]      gx_q, gx_d, gy_q, gy_d;
  logic [CW-1:0]     gk_q, gk_d;
  logic [W-1:0]      mc_q, mc_d, mp_q, mp_d, rem_q, rem_d, rn_q, rn_d;
  logic [PW-1:0]     acc_q, acc_d, p_q, p_d, q_q, q_d, d_q, d_d;
  logic [SW-1:0]     s_q, s_d;
  logic [FW-1:0]     res_num_q, res_num_d, res_den_q, res_den_d;
  rau_pkg::relation_e rel_q, rel_d;
  rau_pkg::status_e   st_q, st_d;

  rau_pkg::ucode_t   uc;
  rau_pkg::kind_e    kind;

  logic              an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0]      an_mag, ad_mag, bn_mag, bd_mag;
  logic              gcd_done;
  logic [W-1:0]      g_val;
  logic [W:0]        div_r2;
  logic              div_ge;
  logic              p_neg, q_neg, d_neg, mk_neg;
  logic [SW-1:0]     p_sv, q_sv, d_sv, addend;
  logic              s_fit, d_fit;
  logic [W-1:0]      num_w, den_w;
  logic [FW-1:0]     num_f, den_f;
  rau_pkg::relation_e rel_w;
  rau_pkg::status_e   st_w;

  assign kind   = rau_pkg::kind_e'(kind_q);
  assign uc     = rau_pkg::ucode_rom(pc_q);

  assign an_neg = an_q[W-1];
  assign ad_neg = ad_q[W-1];
  assign bn_neg = bn_q[W-1];
  assign bd_neg = bd_q[W-1];
  assign an_mag = an_neg ? -an_q : an_q;
  assign ad_mag = ad_neg ? -ad_q : ad_q;
  assign bn_mag = bn_neg ? -bn_q : bn_q;
  assign bd_mag = bd_neg ? -bd_q : bd_q;

  assign gcd_done = (gx_q == '0) || (gy_q == '0);
  assign g_val    = (gx_q | gy_q) << gk_q;
  assign div_r2   = {rem_q, mp_q[W-1]};
  assign div_ge   = div_r2 >= {1'b0, mc_q};

  assign p_neg  = (p_q != '0) &&
                  (an_neg ^ ((kind == rau_pkg::KIND_MUL) ? bn_neg : bd_neg));
  assign q_neg  = (q_q != '0) && (bn_neg ^ ad_neg);
  assign d_neg  = (d_q != '0) &&
                  (ad_neg ^ ((kind == rau_pkg::KIND_DIV) ? bn_neg : bd_neg));
  assign mk_neg = (rn_q != '0) && (an_neg ^ ad_neg);

  assign p_sv = p_neg ? -SW'(p_q) : SW'(p_q);
  assign q_sv = q_neg ? -SW'(q_q) : SW'(q_q);
  assign d_sv = d_neg ? -SW'(d_q) : SW'(d_q);

  assign s_fit = (&s_q[SW-1:W-1]) | ~(|s_q[SW-1:W-1]);
  assign d_fit = (&d_sv[SW-1:W-1]) | ~(|d_sv[SW-1:W-1]);

  always_comb begin
    unique case (kind)
      rau_pkg::KIND_ADD:                   addend = q_sv;
      rau_pkg::KIND_SUB, rau_pkg::KIND_CMP: addend = -q_sv;
      default:                              addend = '0;
    endcase
  end

  always_comb begin
    num_w = '0;
    den_w = W'(1);
    rel_w = rau_pkg::REL_EQUAL;
    st_w  = rau_pkg::ST_OK;
    unique case (kind)
      rau_pkg::KIND_MAKE: begin
        if (ad_mag == '0) begin
          num_w = an_q;
          den_w = '0;
          st_w  = rau_pkg::ST_ZERO_DEN;
        end else begin
          num_w = mk_neg ? -rn_q : rn_q;
          den_w = mp_q;
          if ((!mk_neg && rn_q[W-1]) || mp_q[W-1]) begin
            st_w = rau_pkg::ST_OVERFLOW;
          end
        end
      end
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: begin
        num_w = s_q[W-1:0];
        den_w = d_sv[W-1:0];
        if (d_q == '0) begin
          st_w = rau_pkg::ST_ZERO_DEN;
        end else if (!s_fit || !d_fit) begin
          st_w = rau_pkg::ST_OVERFLOW;
        end
      end
      rau_pkg::KIND_CMP: begin
        priority if ((ad_mag == '0) || (bd_mag == '0)) begin
          st_w = rau_pkg::ST_ZERO_DEN;
        end else if (s_q == '0) begin
          rel_w = rau_pkg::REL_EQUAL;
        end else if (s_q[SW-1] ^ ad_neg ^ bd_neg) begin
          rel_w = rau_pkg::REL_LESS;
        end else begin
          rel_w = rau_pkg::REL_GREATER;
        end
      end
      default: ;
    endcase
  end

  if (W >= FW) begin : g_out_wide
    assign num_f = num_w[FW-1:0];
    assign den_f = den_w[FW-1:0];
  end else begin : g_out_narrow
    assign num_f = {{(FW-W){num_w[W-1]}}, num_w};
    assign den_f = {{(FW-W){den_w[W-1]}}, den_w};
  end

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    pc_d      = pc_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    gk_d      = gk_q;
    mc_d      = mc_q;
    mp_d      = mp_q;
    rem_d     = rem_q;
    rn_d      = rn_q;
    acc_d     = acc_q;
    p_d       = p_q;
    q_d       = q_q;
    d_d       = d_q;
    s_d       = s_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    rel_d     = rel_q;
    st_d      = st_q;

    if (!busy_q) begin
      if (start) begin
        busy_d = 1'b1;
        kind_d = kind_i;
        an_d   = an_w;
        ad_d   = ad_w;
        bn_d   = bn_w;
        bd_d   = bd_w;
        unique case (rau_pkg::kind_e'(kind_i))
          rau_pkg::KIND_MAKE: pc_d = rau_pkg::UPC_GINIT;
          rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL,
          rau_pkg::KIND_DIV, rau_pkg::KIND_CMP: pc_d = rau_pkg::UPC_MLOAD_P;
          default: pc_d = rau_pkg::UPC_FIN_A;
        endcase
      end
    end else begin
      unique case (uc.op)
        rau_pkg::OP_GINIT: begin
          gx_d = an_mag;
          gy_d = ad_mag;
          gk_d = '0;
        end
        rau_pkg::OP_GSTEP: begin
          if (!gcd_done) begin
            priority if (!gx_q[0] && !gy_q[0]) begin
              gx_d = gx_q >> 1;
              gy_d = gy_q >> 1;
              gk_d = gk_q + CW'(1);
            end else if (!gx_q[0]) begin
              gx_d = gx_q >> 1;
            end else if (!gy_q[0]) begin
              gy_d = gy_q >> 1;
            end else if (gx_q >= gy_q) begin
              gx_d = (gx_q - gy_q) >> 1;
            end else begin
              gy_d = (gy_q - gx_q) >> 1;
            end
          end
        end
        rau_pkg::OP_GFIN: begin
          mc_d  = g_val;
          mp_d  = an_mag;
          rem_d = '0;
          cnt_d = CW'(W - 1);
        end
        rau_pkg::OP_DSTEP: begin
          rem_d = div_ge ? W'(div_r2 - {1'b0, mc_q}) : div_r2[W-1:0];
          mp_d  = {mp_q[W-2:0], div_ge};
          cnt_d = cnt_q - CW'(1);
        end
        rau_pkg::OP_DNEXT: begin
          rn_d  = mp_q;
          mp_d  = ad_mag;
          rem_d = '0;
          cnt_d = CW'(W - 1);
        end
        rau_pkg::OP_MLOAD: begin
          acc_d = '0;
          cnt_d = CW'(W - 1);
          unique case (uc.sel)
            rau_pkg::SEL_P: begin
              mc_d = an_mag;
              mp_d = (kind == rau_pkg::KIND_MUL) ? bn_mag : bd_mag;
            end
            rau_pkg::SEL_Q: begin
              mc_d = bn_mag;
              mp_d = ad_mag;
            end
            default: begin
              mc_d = ad_mag;
              mp_d = (kind == rau_pkg::KIND_DIV) ? bn_mag : bd_mag;
            end
          endcase
        end
        rau_pkg::OP_MSTEP: begin
          acc_d = {acc_q[PW-2:0], 1'b0} + (mp_q[W-1] ? PW'(mc_q) : '0);
          mp_d  = {mp_q[W-2:0], 1'b0};
          cnt_d = cnt_q - CW'(1);
        end
        rau_pkg::OP_MSAVE: begin
          unique case (uc.sel)
            rau_pkg::SEL_P: p_d = acc_q;
            rau_pkg::SEL_Q: q_d = acc_q;
            default:        d_d = acc_q;
          endcase
        end
        rau_pkg::OP_SUM: begin
          s_d = p_sv + addend;
        end
        rau_pkg::OP_FIN: begin
          res_num_d = num_f;
          res_den_d = den_f;
          rel_d     = rel_w;
          st_d      = st_w;
        end
        default: ;
      endcase

      unique case (uc.cond)
        rau_pkg::C_NEXT: pc_d = pc_q + PCW'(1);
        rau_pkg::C_LOOP: pc_d = (cnt_q != '0) ? uc.target : pc_q + PCW'(1);
        rau_pkg::C_GCD:  pc_d = gcd_done ? pc_q + PCW'(1) : uc.target;
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pc_q   <= rau_pkg::UPC_GINIT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    gx_q      <= gx_d;
    gy_q      <= gy_d;
    gk_q      <= gk_d;
    mc_q      <= mc_d;
    mp_q      <= mp_d;
    rem_q     <= rem_d;
    rn_q      <= rn_d;
    acc_q     <= acc_d;
    p_q       <= p_d;
    q_q       <= q_d;
    d_q       <= d_d;
    s_q       <= s_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    rel_q     <= rel_d;
    st_q      <= st_d;
  end

  assign busy       = busy_q;
  assign done_o     = done_q;
  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign relation_o = rel_q;
  assign status_o   = st_q;

  `RAU_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result strobe while busy")
  `RAU_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accepted word not started")
  `RAU_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result strobe longer than one cycle")
  `RAU_ASSERT(a_ovf_rel, clk_i, rst_ni, (done_o && (status_o == rau_pkg::ST_OVERFLOW)) |-> (relation_o == rau_pkg::REL_EQUAL), "overflow with compare relation")
  `RAU_ASSERT_CLK(a_reset_idle, clk_i, !rst_ni |=> (!busy && !done_o), "not idle after reset")

endmodule

>>> tb/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction commands through the start/busy handshake and predicts every
// result word independently: GCD reduction for make, exact wide cross products
// for add, sub, mul and div with zero-denominator and overflow status, and
// sign-corrected cross multiplication for compare. A directed set of corner
// words comes first, then random words with mixed idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;
  localparam logic signed [31:0] W_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] W_MIN = 32'sh80000000;
  localparam int RANDOM_WORDS = 625;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_CAP    = 40;

  typedef logic signed [65:0] wide_t;
  localparam wide_t WIDE_MAX = 66'sd2147483647;
  localparam wide_t WIDE_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } cmd_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0]  rel;
    logic [1:0]  st;
  } result_t;

  typedef struct {
    int unsigned idx;
    result_t     res;
  } pending_t;

  class fraction_scoreboard;
    pending_t    pending_results[$];
    int unsigned words_noted;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned kind_seen[8];
    int unsigned zero_den_seen;
    int unsigned overflow_seen;

    function wide_t gcd_of(wide_t x, wide_t y);
      wide_t t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function bit fits_word(wide_t v);
      return v >= WIDE_MIN && v <= WIDE_MAX;
    endfunction

    function result_t fraction_result(cmd_t c);
      wide_t an, ad, bn, bd, rn, rd, x, y, man, mad, g;
      rau_pkg::relation_e rel;
      rau_pkg::status_e st;
      result_t r;
      an = wide_t'(c.a_num);
      ad = wide_t'(c.a_den);
      bn = wide_t'(c.b_num);
      bd = wide_t'(c.b_den);
      rn = 0;
      rd = 1;
      rel = rau_pkg::REL_EQUAL;
      st = rau_pkg::ST_OK;
      case (c.kind)
        rau_pkg::KIND_MAKE: begin
          if (ad == 0) begin
            rn = an;
            rd = 0;
            st = rau_pkg::ST_ZERO_DEN;
          end else begin
            man = (an < 0) ? -an : an;
            mad = (ad < 0) ? -ad : ad;
            g = gcd_of(man, mad);
            rn = man / g;
            rd = mad / g;
            if ((an < 0) != (ad < 0)) rn = -rn;
          end
        end
        rau_pkg::KIND_ADD: begin
          rn = an * bd + bn * ad;
          rd = ad * bd;
        end
        rau_pkg::KIND_SUB: begin
          rn = an * bd - bn * ad;
          rd = ad * bd;
        end
        rau_pkg::KIND_MUL: begin
          rn = an * bn;
          rd = ad * bd;
        end
        rau_pkg::KIND_DIV: begin
          rn = an * bd;
          rd = ad * bn;
        end
        rau_pkg::KIND_CMP: begin
          if (ad == 0 || bd == 0) begin
            st = rau_pkg::ST_ZERO_DEN;
          end else begin
            x = an * bd;
            y = bn * ad;
            if ((ad < 0) != (bd < 0)) begin
              x = -x;
              y = -y;
            end
            rel = (x < y) ? rau_pkg::REL_LESS :
                  (x == y) ? rau_pkg::REL_EQUAL : rau_pkg::REL_GREATER;
          end
        end
        default: ;
      endcase
      if (c.kind >= rau_pkg::KIND_ADD && c.kind <= rau_pkg::KIND_DIV && rd == 0)
        st = rau_pkg::ST_ZERO_DEN;
      if (st == rau_pkg::ST_OK && c.kind <= rau_pkg::KIND_DIV &&
          (!fits_word(rn) || !fits_word(rd)))
        st = rau_pkg::ST_OVERFLOW;
      r.num = rn[31:0];
      r.den = rd[31:0];
      r.rel = rel;
      r.st  = st;
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_t p;
      p.idx = words_noted;
      p.res = fraction_result(c);
      if (p.res.st == rau_pkg::ST_ZERO_DEN) zero_den_seen++;
      if (p.res.st == rau_pkg::ST_OVERFLOW) overflow_seen++;
      kind_seen[c.kind]++;
      words_noted++;
      pending_results.push_back(p);
    endfunction

    function void report_mismatch(int unsigned idx, string what,
                                  logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("MISMATCH word %0d %s: got %h, expected %h", idx, what, got, want);
    endfunction

    function void check_result(result_t got);
      pending_t p;
      if (pending_results.size() == 0) begin
        report_mismatch(results_checked, "unexpected result", got.num, 32'd0);
        return;
      end
      p = pending_results.pop_front();
      results_checked++;
      if (got.num !== p.res.num) report_mismatch(p.idx, "res_num", got.num, p.res.num);
      if (got.den !== p.res.den) report_mismatch(p.idx, "res_den", got.den, p.res.den);
      if (got.rel !== p.res.rel)
        report_mismatch(p.idx, "relation", 32'(got.rel), 32'(p.res.rel));
      if (got.st !== p.res.st)
        report_mismatch(p.idx, "status", 32'(got.st), 32'(p.res.st));
    endfunction

    function void flush_pending();
      pending_t p;
      while (pending_results.size() != 0) begin
        p = pending_results.pop_front();
        report_mismatch(p.idx, "missing result", 32'd0, p.res.num);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = '0;
  logic [31:0] b_num_i = '0;
  logic [31:0] b_den_i = '0;
  logic        done_o;
  logic [31:0] res_num_o;
  logic [31:0] res_den_o;
  logic [1:0]  relation_o;
  logic [1:0]  status_o;

  fraction_scoreboard sb = new();
  bit no_gaps = 1'b0;

  rational_arithmetic_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .done_o     (done_o),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .relation_o (relation_o),
    .status_o   (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({res_num_o, res_den_o, relation_o, status_o});
  end

  function automatic cmd_t mk(logic [2:0] k, logic signed [31:0] an,
                              logic signed [31:0] ad, logic signed [31:0] bn,
                              logic signed [31:0] bd);
    cmd_t c;
    c.kind  = k;
    c.a_num = an;
    c.a_den = ad;
    c.b_num = bn;
    c.b_den = bd;
    return c;
  endfunction

  function automatic logic signed [31:0] small_value();
    logic signed [31:0] v;
    v = $urandom_range(0, 40);
    return v - 20;
  endfunction

  function automatic logic signed [31:0] random_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = small_value();
      3, 4: begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = W_MAX;
          4: v = W_MIN;
          5: v = W_MIN + 1;
          6: v = W_MAX - 1;
          default: v = 2;
        endcase
      end
      5, 6, 7: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(8, 28);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int unsigned sel;
    logic signed [31:0] g, k;
    sel = $urandom_range(0, 99);
    if (sel < 3) c.kind = 3'($urandom_range(6, 7));
    else if (sel < 25) c.kind = rau_pkg::KIND_MAKE;
    else c.kind = 3'($urandom_range(1, 5));
    c.a_num = random_operand();
    c.a_den = random_operand();
    c.b_num = random_operand();
    c.b_den = random_operand();
    if (c.kind == rau_pkg::KIND_MAKE && $urandom_range(0, 1)) begin
      g = $urandom_range(1, 1 << $urandom_range(1, 15));
      c.a_num = g * small_value();
      c.a_den = g * small_value();
    end else if ((c.kind == rau_pkg::KIND_CMP || c.kind == rau_pkg::KIND_SUB) &&
                 $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 9);
      if ($urandom_range(0, 1)) k = -k;
      c.a_num = small_value();
      c.a_den = small_value();
      c.b_num = c.a_num * k;
      c.b_den = c.a_den * k;
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  task automatic send_word(cmd_t c);
    int unsigned gap;
    start   <= 1'b1;
    kind_i  <= c.kind;
    a_num_i <= c.a_num;
    a_den_i <= c.a_den;
    b_num_i <= c.b_num;
    b_den_i <= c.b_den;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_directed();
    send_word(mk(rau_pkg::KIND_MAKE, 6, -4, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, 0, -7, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, 7, 0, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, W_MIN, -1, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, 1, W_MIN, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, W_MIN, W_MIN, 0, 0));
    send_word(mk(rau_pkg::KIND_MAKE, W_MAX, W_MAX - 1, W_MIN, W_MAX));
    send_word(mk(rau_pkg::KIND_MAKE, -12, -18, -1, -1));
    send_word(mk(rau_pkg::KIND_ADD, 1, 2, 1, 3));
    send_word(mk(rau_pkg::KIND_ADD, W_MAX, 1, W_MAX, 1));
    send_word(mk(rau_pkg::KIND_ADD, 1, 0, 1, 3));
    send_word(mk(rau_pkg::KIND_SUB, 1, 2, 1, 2));
    send_word(mk(rau_pkg::KIND_SUB, W_MIN, 1, W_MAX, 1));
    send_word(mk(rau_pkg::KIND_MUL, W_MIN, W_MIN, W_MIN, W_MIN));
    send_word(mk(rau_pkg::KIND_MUL, -3, 4, 5, -7));
    send_word(mk(rau_pkg::KIND_DIV, 2, 3, 0, 5));
    send_word(mk(rau_pkg::KIND_DIV, -3, 4, 5, -7));
    send_word(mk(rau_pkg::KIND_CMP, 1, 2, 1, 3));
    send_word(mk(rau_pkg::KIND_CMP, 1, 3, 1, 2));
    send_word(mk(rau_pkg::KIND_CMP, 2, 4, -1, -2));
    send_word(mk(rau_pkg::KIND_CMP, 1, -2, 1, 3));
    send_word(mk(rau_pkg::KIND_CMP, 1, 0, 1, 1));
    send_word(mk(rau_pkg::KIND_CMP, W_MIN, 1, W_MAX, W_MIN));
    send_word(mk(KIND_UNUSED6, W_MAX, W_MIN, -1, 0));
    send_word(mk(KIND_UNUSED7, -1, -1, -1, -1));
  endtask

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o || !rst_ni) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_word(random_command());
    end
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.flush_pending();
    $display("Sent %0d words: make %0d, add %0d, sub %0d, mul %0d, div %0d, cmp %0d, unused %0d",
             sb.words_noted, sb.kind_seen[rau_pkg::KIND_MAKE], sb.kind_seen[rau_pkg::KIND_ADD],
             sb.kind_seen[rau_pkg::KIND_SUB], sb.kind_seen[rau_pkg::KIND_MUL],
             sb.kind_seen[rau_pkg::KIND_DIV], sb.kind_seen[rau_pkg::KIND_CMP],
             sb.kind_seen[KIND_UNUSED6] + sb.kind_seen[KIND_UNUSED7]);
    $display("Checked %0d results, %0d with zero denominator, %0d with overflow, %0d mismatches",
             sb.results_checked, sb.zero_den_seen, sb.overflow_seen, sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
